@@ design/aes128_block_decrypt_assert.svh @@
// ----------------------------------------------------------------------------
// AES-128 block decrypt assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_DECRYPT_ASSERT_SVH
`define AES128_BLOCK_DECRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define AESBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define AESBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define AESBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AESBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/aesbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block decrypt package
// Types, register codes, S-box tables and round functions.
// ----------------------------------------------------------------------------
package aesbd_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int CFG_IDX_W  = 2;

  typedef logic [127:0] state_t;
  typedef logic [NUM_ROUNDS:0][127:0] rkeys_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } cfg_reg_t;

  localparam logic [2047:0] SBOX_FWD_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] SBOX_INV_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    logic [10:0] idx;
    idx = 11'd2047 - {b, 3'b000};
    return SBOX_FWD_TBL[idx -: 8];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] b);
    logic [10:0] idx;
    idx = 11'd2047 - {b, 3'b000};
    return SBOX_INV_TBL[idx -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of the block sits at the top end of the word for k = 0.
  function automatic logic [7:0] get_byte(input state_t s, input int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function automatic state_t inv_sub_bytes(input state_t s);
    state_t o;
    for (int k = 0; k < 16; k++) begin
      o[127 - 8 * k -: 8] = sbox_inv(get_byte(s, k));
    end
    return o;
  endfunction

  function automatic state_t inv_shift_rows(input state_t s);
    state_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = get_byte(s, 4 * c + r);
      end
    end
    return o;
  endfunction

  function automatic state_t inv_mix_columns(input state_t s);
    state_t o;
    logic [3:0][7:0] a, m9, m11, m13, m14;
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]   = get_byte(s, 4 * c + i);
        x2     = xtime(a[i]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[i]  = x8 ^ a[i];
        m11[i] = x8 ^ x2 ^ a[i];
        m13[i] = x8 ^ x4 ^ a[i];
        m14[i] = x8 ^ x4 ^ x2;
      end
      o[127 - 8 * (4 * c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      o[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      o[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      o[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return o;
  endfunction

  // One step of the forward key schedule.
  function automatic state_t key_step(input state_t p, input logic [7:0] rcon);
    state_t q;
    q[127:120] = get_byte(p, 0) ^ sbox_fwd(get_byte(p, 13)) ^ rcon;
    q[119:112] = get_byte(p, 1) ^ sbox_fwd(get_byte(p, 14));
    q[111:104] = get_byte(p, 2) ^ sbox_fwd(get_byte(p, 15));
    q[103:96]  = get_byte(p, 3) ^ sbox_fwd(get_byte(p, 12));
    for (int k = 4; k < 16; k++) begin
      q[127 - 8 * k -: 8] = get_byte(p, k) ^ q[127 - 8 * (k - 4) -: 8];
    end
    return q;
  endfunction

endpackage

@@ design/aesbd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block decrypt channel interfaces
// Valid/ready channels for ciphertext items, plaintext items and key writes.
// ----------------------------------------------------------------------------
interface aesbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        last_block;
  modport source (output valid, block_high, block_low, last_block, input ready);
  modport sink   (input valid, block_high, block_low, last_block, output ready);
endinterface

interface aesbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic        last_out;
  modport source (output valid, plain_high, plain_low, last_out, input ready);
  modport sink   (input valid, plain_high, plain_low, last_out, output ready);
endinterface

interface aesbd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aesbd_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/aesbd_keysched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 decrypt key schedule
// Holds the key registers and expands them, one round key per cycle.
// ----------------------------------------------------------------------------
module aesbd_keysched (
  input  logic               clk,
  input  logic               rst_n,
  aesbd_cfg_if.sink          cfg_ch,
  output aesbd_pkg::rkeys_t  rkeys,
  output logic               busy
);

  logic [63:0]        key_high_r, key_high_nxt;
  logic [63:0]        key_low_r, key_low_nxt;
  aesbd_pkg::state_t  cur_r, cur_nxt;
  logic [7:0]         rcon_r, rcon_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  aesbd_pkg::state_t  step;
  aesbd_pkg::state_t  rk_r [1:10];
  logic               wr_key;

  assign cfg_ch.ready = 1'b1;
  assign step = aesbd_pkg::key_step(cur_r, rcon_r);

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    wr_key       = 1'b0;
    if (cfg_ch.valid) begin
      if (cfg_ch.index == aesbd_pkg::REG_KEY_HIGH) begin
        key_high_nxt = cfg_ch.data;
        wr_key       = 1'b1;
      end else if (cfg_ch.index == aesbd_pkg::REG_KEY_LOW) begin
        key_low_nxt = cfg_ch.data;
        wr_key      = 1'b1;
      end
    end
    if (wr_key) begin
      cur_nxt  = {key_high_nxt, key_low_nxt};
      rcon_nxt = 8'h01;
      cnt_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cur_nxt  = step;
      rcon_nxt = aesbd_pkg::xtime(rcon_r);
      cnt_nxt  = cnt_r + 4'd1;
      busy_nxt = (cnt_r != 4'(aesbd_pkg::NUM_ROUNDS));
    end else begin
      cur_nxt  = cur_r;
      rcon_nxt = rcon_r;
      cnt_nxt  = cnt_r;
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      cur_r      <= '0;
      rcon_r     <= 8'h01;
      cnt_r      <= 4'd1;
      busy_r     <= 1'b1;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      cur_r      <= cur_nxt;
      rcon_r     <= rcon_nxt;
      cnt_r      <= cnt_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // Middle round keys are stored already passed through InvMixColumns.
  always_ff @(posedge clk) begin
    if (busy_r && !wr_key) begin
      rk_r[cnt_r] <= (cnt_r == 4'(aesbd_pkg::NUM_ROUNDS)) ? step
                                                         : aesbd_pkg::inv_mix_columns(step);
    end
  end

  always_comb begin
    rkeys[0] = {key_high_r, key_low_r};
    for (int i = 1; i <= aesbd_pkg::NUM_ROUNDS; i++) begin
      rkeys[i] = rk_r[i];
    end
  end

  assign busy = busy_r;

endmodule

@@ design/aesbd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 decrypt round cell
// One inverse round, registered; hands its state to the next cell.
// ----------------------------------------------------------------------------
module aesbd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               mix_en,
  input  logic               in_valid,
  input  aesbd_pkg::state_t  in_state,
  input  logic               in_last,
  input  aesbd_pkg::state_t  rkey,
  output logic               out_valid,
  output aesbd_pkg::state_t  out_state,
  output logic               out_last
);

  aesbd_pkg::state_t shifted;
  aesbd_pkg::state_t mixed;
  logic              valid_r;
  aesbd_pkg::state_t state_r;
  logic              last_r;

  assign shifted = aesbd_pkg::inv_shift_rows(aesbd_pkg::inv_sub_bytes(in_state));
  assign mixed   = mix_en ? aesbd_pkg::inv_mix_columns(shifted) : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= mixed ^ rkey;
      last_r  <= in_last;
    end
  end

  assign out_valid = valid_r;
  assign out_state = state_r;
  assign out_last  = last_r;

endmodule

@@ design/aes128_block_decrypt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block decrypt
// Fully unrolled equivalent inverse cipher, one 128-bit block per cycle when unstalled.
// ----------------------------------------------------------------------------
// The block decrypts one AES-128 ciphertext item per clock cycle in ECB
// fashion unless the output stalls or round keys are being expanded. An item
// passes an input register that adds round key 10 and then a row of ten round
// cells; a new item may be accepted in every cycle with the same exceptions.
// The whole row moves only when the output register is empty or being taken,
// so a stalled output holds every item in place. After reset, and after every
// write of a key register, the key schedule computes the round keys, one per
// cycle; in_ch.ready stays low during that time while key writes are still
// taken. The last-block marker travels with its item unchanged.
module aes128_block_decrypt (
  input  logic         clk,
  input  logic         rst_n,
  aesbd_in_if.sink     in_ch,
  aesbd_out_if.source  out_ch,
  aesbd_cfg_if.sink    cfg_ch
);

  `include "aes128_block_decrypt_assert.svh"

  localparam int NR = aesbd_pkg::NUM_ROUNDS;

  aesbd_pkg::rkeys_t  rkeys;
  logic               ks_busy;
  logic               advance;
  logic               in_take;
  logic               key_wr;

  // Stage 0 is the input register; stages 1 to NR are the round cells.
  logic               stage_valid [0:NR];
  aesbd_pkg::state_t  stage_state [0:NR];
  logic               stage_last  [0:NR];

  logic               s0_valid_r;
  aesbd_pkg::state_t  s0_state_r;
  logic               s0_last_r;

  aesbd_keysched u_keysched (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .rkeys  (rkeys),
    .busy   (ks_busy)
  );

  // The row advances whenever the output slot is free or being emptied.
  assign advance      = !stage_valid[NR] || out_ch.ready;
  assign in_ch.ready  = advance && !ks_busy;
  assign in_take      = in_ch.valid && in_ch.ready;

  // A write that lands on one of the two key registers.
  assign key_wr = cfg_ch.valid && cfg_ch.ready &&
                  (cfg_ch.index == aesbd_pkg::REG_KEY_HIGH ||
                   cfg_ch.index == aesbd_pkg::REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (advance) begin
      s0_valid_r <= in_take;
    end
  end

  // Initial AddRoundKey with the last round key.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_state_r <= {in_ch.block_high, in_ch.block_low} ^ rkeys[NR];
      s0_last_r  <= in_ch.last_block;
    end
  end

  assign stage_valid[0] = s0_valid_r;
  assign stage_state[0] = s0_state_r;
  assign stage_last[0]  = s0_last_r;

  // Cell i uses round key NR - i; the final cell skips InvMixColumns.
  for (genvar i = 1; i <= NR; i++) begin : g_round
    aesbd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .mix_en    ((i != NR) ? 1'b1 : 1'b0),
      .in_valid  (stage_valid[i-1]),
      .in_state  (stage_state[i-1]),
      .in_last   (stage_last[i-1]),
      .rkey      (rkeys[NR-i]),
      .out_valid (stage_valid[i]),
      .out_state (stage_state[i]),
      .out_last  (stage_last[i])
    );
  end

  assign out_ch.valid      = stage_valid[NR];
  assign out_ch.plain_high = stage_state[NR][127:64];
  assign out_ch.plain_low  = stage_state[NR][63:0];
  assign out_ch.last_out   = stage_last[NR];

  `AESBD_ASSERT_IMPLY(a_no_input_while_expanding, clk, rst_n, ks_busy, !in_ch.ready)
  `AESBD_ASSERT_NEXT(a_accept_fills_stage0, clk, rst_n, in_take, s0_valid_r)
  `AESBD_ASSERT_NEXT(a_key_write_starts_expand, clk, rst_n, key_wr, ks_busy)
  `AESBD_ASSERT_NEXT(a_stall_holds_row, clk, rst_n, !advance, $stable(stage_valid[NR]))

endmodule

@@ bench/aesbd_plain_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 decrypt plaintext checker
// Tracks key writes, predicts the plaintext of every accepted ciphertext item
// and compares it, in order, with every accepted plaintext item.
// ----------------------------------------------------------------------------
module aesbd_plain_checker (
  input  logic  clk,
  input  logic  rst_n,
  aesbd_in_if   in_m,
  aesbd_out_if  out_m,
  aesbd_cfg_if  cfg_m,
  output int    fail_count,
  output int    pending
);

  typedef logic [0:15][7:0] aes_bytes_t;
  typedef struct {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        last_out;
  } plaintext_t;

  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];
  logic [63:0] key_hi_copy, key_lo_copy;
  aes_bytes_t  round_keys [0:10];
  plaintext_t  plain_q [$];
  int          mismatches;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  function automatic aes_bytes_t unmix(input aes_bytes_t s);
    aes_bytes_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[4*c+r] = gf_mul(s[4*c+r], 8'h0e) ^ gf_mul(s[4*c+(r+1)%4], 8'h0b)
                 ^ gf_mul(s[4*c+(r+2)%4], 8'h0d) ^ gf_mul(s[4*c+(r+3)%4], 8'h09);
      end
    end
    return o;
  endfunction

  function automatic aes_bytes_t unsub_unshift(input aes_bytes_t s);
    aes_bytes_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[4*((c+r)%4)+r] = inv_sub[s[4*c+r]];
      end
    end
    return o;
  endfunction

  function automatic void schedule_keys();
    logic [7:0] rcon;
    rcon = 8'h01;
    round_keys[0] = {key_hi_copy, key_lo_copy};
    for (int n = 1; n <= 10; n++) begin
      round_keys[n][0] = round_keys[n-1][0] ^ fwd_sub[round_keys[n-1][13]] ^ rcon;
      round_keys[n][1] = round_keys[n-1][1] ^ fwd_sub[round_keys[n-1][14]];
      round_keys[n][2] = round_keys[n-1][2] ^ fwd_sub[round_keys[n-1][15]];
      round_keys[n][3] = round_keys[n-1][3] ^ fwd_sub[round_keys[n-1][12]];
      for (int k = 4; k < 16; k++) round_keys[n][k] = round_keys[n-1][k] ^ round_keys[n][k-4];
      rcon = dbl(rcon);
    end
  endfunction

  function automatic plaintext_t decrypt_block(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic last);
    aes_bytes_t st;
    plaintext_t p;
    st = {hi, lo} ^ round_keys[10];
    for (int n = 9; n >= 1; n--) st = unmix(unsub_unshift(st)) ^ unmix(round_keys[n]);
    st = unsub_unshift(st) ^ round_keys[0];
    p.plain_high = st[0:7];
    p.plain_low  = st[8:15];
    p.last_out   = last;
    return p;
  endfunction

  // S-boxes are built from the field inverse and the affine map.
  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int i = 0; i < 254; i++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = s;
      inv_sub[s] = x[7:0];
    end
    key_hi_copy = '0;
    key_lo_copy = '0;
    schedule_keys();
    mismatches = 0;
  end

  always @(posedge clk) begin
    plaintext_t want;
    if (!rst_n) begin
      key_hi_copy = '0;
      key_lo_copy = '0;
      schedule_keys();
      plain_q.delete();
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        if (cfg_m.index == aesbd_pkg::REG_KEY_HIGH) key_hi_copy = cfg_m.data;
        else if (cfg_m.index == aesbd_pkg::REG_KEY_LOW) key_lo_copy = cfg_m.data;
        schedule_keys();
      end
      if (in_m.valid && in_m.ready)
        plain_q.push_back(decrypt_block(in_m.block_high, in_m.block_low, in_m.last_block));
      if (out_m.valid && out_m.ready) begin
        if (plain_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: plaintext item with none expected: %h %h %b", $realtime,
                     out_m.plain_high, out_m.plain_low, out_m.last_out);
        end else begin
          want = plain_q.pop_front();
          if (want.plain_high !== out_m.plain_high || want.plain_low !== out_m.plain_low ||
              want.last_out !== out_m.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: plaintext mismatch: expected %h %h %b, got %h %h %b", $realtime,
                       want.plain_high, want.plain_low, want.last_out,
                       out_m.plain_high, out_m.plain_low, out_m.last_out);
          end
        end
      end
    end
    fail_count = mismatches;
    pending    = plain_q.size();
  end

endmodule

@@ bench/tb_aes128_block_decrypt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block decrypt testbench
// Drives ciphertext items in random bursts under several keys, stalls the
// plaintext side, and lets the checker compare every plaintext item.
// ----------------------------------------------------------------------------
module tb_aes128_block_decrypt;

  // Index codes outside the register map; writes to them must be dropped.
  localparam logic [aesbd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [aesbd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // The drain wait covers the depth of the pipeline with a little margin on top.
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   rx_hold;
  bit   long_hold_req;

  aesbd_in_if  in_ch ();
  aesbd_out_if out_ch ();
  aesbd_cfg_if cfg_ch ();

  aes128_block_decrypt uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  aesbd_plain_checker plain_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_m       (in_ch),
    .out_m      (out_ch),
    .cfg_m      (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Hands one ciphertext item over and returns at the edge that accepts it.
  // The valid line is left high so that a following item can go straight on.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic last);
    in_ch.valid      <= 1'b1;
    in_ch.block_high <= hi;
    in_ch.block_low  <= lo;
    in_ch.last_block <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Key registers are only touched once every plaintext item is out and the
  // pipeline has had time to drain.
  task automatic write_key_reg(input logic [aesbd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random bursts of items. Every few bursts the sender runs without gaps, so
  // that back to back acceptance is exercised as well.
  task automatic random_blocks(input int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_block(rand64(), rand64(), ($urandom_range(0, 7) == 0));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end
  endtask

  // The receiver mixes three moods: always ready, coin flips and mostly
  // stalled. A long hold-off, asked for by the stimulus, fills the pipeline
  // and pushes back on the sender.
  initial begin
    int mood;
    int mood_left;
    out_ch.ready <= 1'b0;
    mood      = 0;
    mood_left = 0;
    rx_hold   = 0;
    forever begin
      @(posedge clk);
      if (mood_left == 0) begin
        mood      = $urandom_range(0, 2);
        mood_left = $urandom_range(20, 120);
      end
      mood_left--;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold       = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        case (mood)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] key_hi, key_lo;
    idle_cycles       = 0;
    long_hold_req     = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.block_high <= '0;
    in_ch.block_low  <= '0;
    in_ch.last_block <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= aesbd_pkg::REG_KEY_HIGH;
    cfg_ch.data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The key has never been written, so the all-zero key is in force.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    wait_drained();

    // Standard test vector; the plaintext must read 00112233...eeff.
    write_key_reg(aesbd_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_key_reg(aesbd_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    wait_drained();

    // Writes to indexes outside the map must leave the key alone.
    write_key_reg(REG_SPARE_A, '1);
    write_key_reg(REG_SPARE_B, 64'h5a5a5a5a5a5a5a5a);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    wait_drained();

    // Key at both extremes.
    write_key_reg(aesbd_pkg::REG_KEY_HIGH, '1);
    write_key_reg(aesbd_pkg::REG_KEY_LOW, '1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
    wait_drained();
    write_key_reg(aesbd_pkg::REG_KEY_HIGH, '0);
    write_key_reg(aesbd_pkg::REG_KEY_LOW, '0);
    send_block('1, '0, 1'b0);
    send_block('0, '1, 1'b1);
    wait_drained();

    // Random phases, each under its own key. The second one starts with a
    // long hold-off on the plaintext side while items keep coming.
    for (int phase = 0; phase < 6; phase++) begin
      key_hi = rand64();
      key_lo = rand64();
      if (phase == 4) key_hi = '1;
      if (phase == 5) key_lo = '0;
      write_key_reg(aesbd_pkg::REG_KEY_HIGH, key_hi);
      write_key_reg(aesbd_pkg::REG_KEY_LOW, key_lo);
      if (phase == 1) long_hold_req = 1'b1;
      random_blocks(320);
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/aesbd_pkg.sv
design/aesbd_if.sv
design/aesbd_keysched.sv
design/aesbd_cell.sv
design/aes128_block_decrypt.sv
bench/aesbd_plain_checker.sv
bench/tb_aes128_block_decrypt.sv
